>>> rtl/rc4_pkg.sv
package rc4_pkg;

  // permutation table geometry
  localparam int TABLE_SIZE = 256;
  localparam int BYTE_W     = 8;
  localparam int PERM_AW    = $clog2(TABLE_SIZE);

  // key registers
  localparam int KEY_MAX_BYTES_DEF = 16;
  localparam int KEY_SLOTS         = 16;
  localparam int KEY_SEL_W         = $clog2(KEY_SLOTS);
  localparam int KEY_LEN_W         = 5;
  localparam int KEY_HALF_W        = 64;
  localparam int KEY_VEC_W         = 2 * KEY_HALF_W;

  localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RST  = KEY_LEN_W'(3);
  localparam logic [KEY_HALF_W-1:0] KEY_LOW_RST  = KEY_HALF_W'(459779);
  localparam logic [KEY_HALF_W-1:0] KEY_HIGH_RST = '0;

  // configuration port
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 64;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_KEY_LOW    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH   = REG_IDX_W'(2);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_REKEY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [KEY_LEN_W-1:0] key_length;
    logic [KEY_VEC_W-1:0] key_bytes;
  } key_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD_I,
    ST_KS_RD_J,
    ST_KS_WR_I,
    ST_KS_WR_J,
    ST_GEN_RD_I,
    ST_GEN_RD_J,
    ST_GEN_SW_I,
    ST_GEN_SW_J
  } state_e;

endpackage

>>> rtl/rc4_ram.sv
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rc4_front.sv
module rc4_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [rc4_pkg::BYTE_W-1:0]   s_tdata_i,
  input  logic                         s_tuser_i,
  output logic                         item_valid_o,
  output rc4_pkg::item_t               item_o,
  input  logic                         pop_i
);
  import rc4_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t           slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  item_t           in_item;

  // classify the incoming word
  always_comb begin
    in_item.kind = s_tuser_i ? KIND_REKEY : KIND_DATA;
    in_item.data = s_tdata_i;
  end

  assign s_tready_o   = (cnt_q != CntW'(QUEUE_DEPTH));
  assign push         = s_tvalid_i && s_tready_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

>>> rtl/rc4_back.sv
module rc4_back #(
  parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rc4_pkg::key_cfg_t          key_cfg_i,
  input  logic                       item_valid_i,
  input  rc4_pkg::item_t             item_i,
  output logic                       pop_o,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [rc4_pkg::BYTE_W-1:0] m_tdata_o
);
  import rc4_pkg::*;

  localparam int KeyPosW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam logic [PERM_AW-1:0] LastIdx = PERM_AW'(TABLE_SIZE - 1);

  state_e               state_q, state_d;
  logic [PERM_AW-1:0]   cnt_q, cnt_d;
  logic [BYTE_W-1:0]    acc_q, acc_d;
  logic [KeyPosW-1:0]   pos_q, pos_d;
  logic [PERM_AW-1:0]   i_q, i_d;
  logic [PERM_AW-1:0]   j_q, j_d;
  logic [BYTE_W-1:0]    si_q, si_d;
  logic [BYTE_W-1:0]    sj_q, sj_d;
  logic [PERM_AW-1:0]   t_q, t_d;
  logic [BYTE_W-1:0]    data_q, data_d;
  logic                 pend_q, pend_d;
  logic                 keyed_q, keyed_d;
  logic                 out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]    out_data_q, out_data_d;

  logic                 ram_we;
  logic [PERM_AW-1:0]   ram_waddr;
  logic [BYTE_W-1:0]    ram_wdata;
  logic [PERM_AW-1:0]   ram_raddr;
  logic [BYTE_W-1:0]    ram_rdata;

  logic                 out_free;
  logic                 take;
  logic [KEY_LEN_W-1:0] eff_len;
  logic [KEY_LEN_W-1:0] pos_p1;
  logic [KEY_SEL_W-1:0] key_sel;
  logic [BYTE_W-1:0]    key_byte;
  logic [BYTE_W-1:0]    acc_n;
  logic [PERM_AW-1:0]   j_n;
  logic [PERM_AW-1:0]   t_n;
  logic [BYTE_W-1:0]    ks;

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_SIZE)
  ) u_perm (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // one item in flight, so a data word is taken only when the result slot is free
  assign out_free = !out_valid_q || m_tready_i;
  assign take     = item_valid_i && (item_i.kind == KIND_REKEY || out_free);

  // key length clamp and cyclic key position
  always_comb begin
    if (key_cfg_i.key_length == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_cfg_i.key_length > KEY_LEN_W'(KEY_MAX_BYTES)) begin
      eff_len = KEY_LEN_W'(KEY_MAX_BYTES);
    end else begin
      eff_len = key_cfg_i.key_length;
    end
  end

  assign pos_p1   = KEY_LEN_W'(pos_q) + KEY_LEN_W'(1);
  assign key_sel  = KEY_SEL_W'(pos_q);
  assign key_byte = key_cfg_i.key_bytes[BYTE_W*key_sel +: BYTE_W];

  assign acc_n = acc_q + ram_rdata + key_byte;
  assign j_n   = j_q + ram_rdata;
  assign t_n   = si_q + ram_rdata;

  // s[t] after the swap: bypass the two words just exchanged
  always_comb begin
    if (t_q == i_q) begin
      ks = sj_q;
    end else if (t_q == j_q) begin
      ks = si_q;
    end else begin
      ks = ram_rdata;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (item_i.kind == KIND_REKEY || !keyed_q) begin
            state_d = ST_INIT;
          end else begin
            state_d = ST_GEN_RD_J;
          end
        end
      end
      ST_INIT: begin
        if (cnt_q == LastIdx) begin
          state_d = ST_KS_RD_I;
        end
      end
      ST_KS_RD_I: state_d = ST_KS_RD_J;
      ST_KS_RD_J: state_d = ST_KS_WR_I;
      ST_KS_WR_I: state_d = ST_KS_WR_J;
      ST_KS_WR_J: begin
        if (cnt_q != LastIdx) begin
          state_d = ST_KS_RD_I;
        end else if (pend_q) begin
          state_d = ST_GEN_RD_I;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_GEN_RD_I: state_d = ST_GEN_RD_J;
      ST_GEN_RD_J: state_d = ST_GEN_SW_I;
      ST_GEN_SW_I: state_d = ST_GEN_SW_J;
      ST_GEN_SW_J: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // table port and queue pop
  always_comb begin
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = cnt_q;
    ram_raddr = i_q + PERM_AW'(1);
    case (state_q)
      ST_IDLE:    pop_o = take;
      ST_INIT:    ram_we = 1'b1;
      ST_KS_RD_I: ram_raddr = cnt_q;
      ST_KS_RD_J: ram_raddr = acc_n;
      ST_KS_WR_I: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_KS_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = acc_q;
        ram_wdata = si_q;
      end
      ST_GEN_RD_J: ram_raddr = j_n;
      ST_GEN_SW_I: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        ram_raddr = t_n;
      end
      ST_GEN_SW_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    data_d      = data_q;
    pend_d      = pend_q;
    keyed_d     = keyed_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          data_d = item_i.data;
          pend_d = (item_i.kind == KIND_DATA);
          cnt_d  = '0;
        end
      end
      ST_INIT: begin
        cnt_d = cnt_q + PERM_AW'(1);
        acc_d = '0;
        pos_d = '0;
      end
      ST_KS_RD_J: begin
        acc_d = acc_n;
        si_d  = ram_rdata;
      end
      ST_KS_WR_J: begin
        cnt_d = cnt_q + PERM_AW'(1);
        pos_d = (pos_p1 >= eff_len) ? '0 : KeyPosW'(pos_p1);
        if (cnt_q == LastIdx) begin
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
        end
      end
      ST_GEN_RD_J: begin
        i_d  = i_q + PERM_AW'(1);
        j_d  = j_n;
        si_d = ram_rdata;
      end
      ST_GEN_SW_I: begin
        sj_d = ram_rdata;
        t_d  = t_n;
      end
      ST_GEN_SW_J: begin
        out_valid_d = 1'b1;
        out_data_d  = data_q ^ ks;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pend_q      <= 1'b0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      pend_q      <= pend_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    pos_q      <= pos_d;
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    data_q     <= data_d;
    out_data_q <= out_data_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

>>> rtl/rc4_stream_cipher_top.sv
// rc4 stream cipher, one byte per word. a word with tuser set rekeys: the key schedule
// builds the 256-byte permutation from the configured key bytes (used cyclically, length
// clamped to 1..KEY_MAX_BYTES) and clears i and j; it gives no output word. a data word
// returns data xor the next keystream byte, so the same stream encrypts and decrypts. a data
// word seen before any rekey runs the schedule first. the permutation lives in one
// single-write, single-read ram, and every table access goes through it: a data byte reads
// s[i], reads s[j], writes s[i] while reading s[t], then writes s[j]; the key schedule fills
// the identity one entry a cycle, then per swap reads s[i], reads s[j], writes s[i] and s[j].
// a two-word queue in front lets the input keep flowing while the engine works, and a
// result register lets the engine finish while the sink stalls. key registers sit on the
// apb port at byte addresses 0 (key_length), 8 (key bytes 0..7), 16 (key bytes 8..15);
// write them only while the block is idle, they take effect at the next key schedule.
module rc4_stream_cipher_top #(
  parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]                  s_axis_tuser_i,   // [0] op: 0 data, 1 rekey
  // output stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o,   // [7:0] out_byte
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rc4_pkg::CFG_AW-1:0]  paddr,
  input  logic [rc4_pkg::CFG_DW-1:0]  pwdata,
  output logic [rc4_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import rc4_pkg::*;

  logic [KEY_LEN_W-1:0]  key_len_q;
  logic [KEY_HALF_W-1:0] key_low_q;
  logic [KEY_HALF_W-1:0] key_high_q;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;
  key_cfg_t              key_cfg;

  logic                  q_valid;
  item_t                 q_item;
  logic                  q_pop;

  // apb register file, 8-byte register stride
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q  <= KEY_LEN_RST;
      key_low_q  <= KEY_LOW_RST;
      key_high_q <= KEY_HIGH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KEY_LENGTH: key_len_q  <= pwdata[KEY_LEN_W-1:0];
        REG_KEY_LOW:    key_low_q  <= pwdata;
        REG_KEY_HIGH:   key_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_LENGTH: prdata = CFG_DW'(key_len_q);
      REG_KEY_LOW:    prdata = key_low_q;
      REG_KEY_HIGH:   prdata = key_high_q;
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    key_cfg.key_length = key_len_q;
    key_cfg.key_bytes  = {key_high_q, key_low_q};
  end

  // front: accept and classify words into the queue
  rc4_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_o   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tuser_i    (s_axis_tuser_i[0]),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .pop_i        (q_pop)
  );

  // back: key schedule and keystream generator around the permutation ram
  rc4_back #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_cfg_i    (key_cfg),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_o    (m_axis_tdata_o)
  );

  // the engine never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a data word starts only with the result register emptying, so nothing is overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && q_item.kind == KIND_DATA |=> !m_axis_tvalid_o)
    else $error("data word started while result register busy");

  // an empty queue always has room
  assert property (@(posedge clk_i) disable iff (!rst_ni) !q_valid |-> s_axis_tready_o)
    else $error("input stalled with empty queue");

  // key length write lands in the register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && reg_idx == REG_KEY_LENGTH |=> key_len_q == $past(pwdata[KEY_LEN_W-1:0]))
    else $error("key length write lost");

endmodule
